/* sv/ppu_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and register map of the particle pool update unit.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int PARTICLES = 32;
    localparam int SLOT_W    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CNT_W     = $clog2(PARTICLES + 1);

    localparam int PADDR_W = 5;

    localparam logic [PADDR_W-1:0] ADDR_LIFE_MAX    = 5'd0;
    localparam logic [PADDR_W-1:0] ADDR_DECAY_HORIZ = 5'd4;
    localparam logic [PADDR_W-1:0] ADDR_DECAY_VERT  = 5'd8;
    localparam logic [PADDR_W-1:0] ADDR_GROWTH_RATE = 5'd12;
    localparam logic [PADDR_W-1:0] ADDR_START_SIZE  = 5'd16;

    localparam logic ACTION_SPAWN = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] spawn_x;
        logic [31:0] spawn_y;
        logic [31:0] spawn_z;
        logic [31:0] start_vx;
        logic [31:0] start_vy;
        logic [31:0] start_vz;
        logic [15:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [5:0]  slot;
        logic [31:0] cur_x;
        logic [31:0] cur_y;
        logic [31:0] cur_z;
        logic [31:0] cur_size;
        logic [7:0]  alpha;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] life_max;
        logic [15:0] decay_horizontal;
        logic [15:0] decay_vertical;
        logic [15:0] growth_rate;
        logic [31:0] start_size;
    } t_cfg;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [23:0] num;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [7:0]  quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SPAWN,
        ST_FULL,
        ST_TSCAN,
        ST_RD,
        ST_PX,
        ST_PY,
        ST_PZ,
        ST_VX,
        ST_VY,
        ST_VZ,
        ST_G1,
        ST_G2,
        ST_G3,
        ST_ALPHA,
        ST_EMIT,
        ST_OUT
    } t_state;

endpackage

/* sv/ppu_if.sv */
// ----------------------------------------------------------------------------
// ppu_in_if / ppu_out_if
// Valid/ready channels of the particle pool update unit.
// ----------------------------------------------------------------------------
interface ppu_in_if;
    logic               valid;
    logic               ready;
    ppu_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppu_out_if;
    logic               valid;
    logic               ready;
    ppu_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/ppu_cfg.sv */
// ----------------------------------------------------------------------------
// ppu_cfg
// APB register file holding the pool configuration.
// ----------------------------------------------------------------------------
module ppu_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppu_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ppu_pkg::t_cfg                o_cfg
);
    ppu_pkg::t_cfg r_cfg;
    logic          wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.life_max         <= 16'd13107;
            r_cfg.decay_horizontal <= 16'd3277;
            r_cfg.decay_vertical   <= 16'd32768;
            r_cfg.growth_rate      <= 16'd8192;
            r_cfg.start_size       <= 32'd16384;
        end else if (wr) begin
            case (paddr)
                ppu_pkg::ADDR_LIFE_MAX:    r_cfg.life_max         <= pwdata[15:0];
                ppu_pkg::ADDR_DECAY_HORIZ: r_cfg.decay_horizontal <= pwdata[15:0];
                ppu_pkg::ADDR_DECAY_VERT:  r_cfg.decay_vertical   <= pwdata[15:0];
                ppu_pkg::ADDR_GROWTH_RATE: r_cfg.growth_rate      <= pwdata[15:0];
                ppu_pkg::ADDR_START_SIZE:  r_cfg.start_size       <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ppu_pkg::ADDR_LIFE_MAX:    prdata = {16'd0, r_cfg.life_max};
            ppu_pkg::ADDR_DECAY_HORIZ: prdata = {16'd0, r_cfg.decay_horizontal};
            ppu_pkg::ADDR_DECAY_VERT:  prdata = {16'd0, r_cfg.decay_vertical};
            ppu_pkg::ADDR_GROWTH_RATE: prdata = {16'd0, r_cfg.growth_rate};
            ppu_pkg::ADDR_START_SIZE:  prdata = r_cfg.start_size;
            default:                   prdata = 32'd0;
        endcase
    end
endmodule

/* sv/ppu_div.sv */
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider for alpha: quotient of a 24-bit numerator, 8 bits kept
// with saturation at 255. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppu_pkg::t_div_req i_req,
    output ppu_pkg::t_div_rsp o_rsp
);
    logic [23:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [23:0] r_quo;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] trial;

    assign trial = {r_rem[15:0], r_num[23]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd23) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= 17'd0;
            r_quo <= 24'd0;
            r_cnt <= 5'd0;
        end else if (r_busy) begin
            r_num <= {r_num[22:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
            if (trial >= {1'b0, r_den}) begin
                r_rem <= trial - {1'b0, r_den};
                r_quo <= {r_quo[22:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[22:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = (r_quo[23:8] != 16'd0) ? 8'hFF : r_quo[7:0];
endmodule

/* sv/ppu_core.sv */
// ----------------------------------------------------------------------------
// ppu_core
// Sequencer over the particle stores with one shared 33x17 multiplier.
// ----------------------------------------------------------------------------
module ppu_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppu_pkg::t_cfg     i_cfg,
    ppu_in_if.sink            in_ch,
    ppu_out_if.source         out_ch,
    output ppu_pkg::t_div_req o_div_req,
    input  ppu_pkg::t_div_rsp i_div_rsp
);
    localparam int SW = ppu_pkg::SLOT_W;
    localparam int CW = ppu_pkg::CNT_W;

    logic [31:0] pos_mem [ppu_pkg::PARTICLES][3];
    logic [31:0] vel_mem [ppu_pkg::PARTICLES][3];
    logic [31:0] size_mem[ppu_pkg::PARTICLES];
    logic [15:0] r_life  [ppu_pkg::PARTICLES];

    ppu_pkg::t_state   r_state, n_state;
    ppu_pkg::t_in_item r_item;
    ppu_pkg::t_out_item r_out;
    logic              r_out_valid;
    logic [CW-1:0]     r_idx;
    logic [SW-1:0]     r_slot;
    logic              r_found;
    logic [SW-1:0]     r_lastidx;
    logic signed [31:0] r_p[3];
    logic signed [31:0] r_v[3];
    logic [31:0]       r_sz;
    logic [63:0]       r_prod;
    logic [31:0]       r_grow;
    logic [7:0]        r_alpha;
    logic              r_div_skip;

    // shared multiplier
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [SW-1:0] idx_s;
    assign idx_s = r_idx[SW-1:0];

    logic        idx_end;
    assign idx_end = (r_idx == CW'(ppu_pkg::PARTICLES));

    logic signed [33:0] psum;
    logic signed [31:0] psat;
    logic [15:0] dt;
    logic [15:0] life_cur;
    assign dt = r_item.time_step;
    assign life_cur = r_life[r_slot];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ppu_pkg::ST_PX: begin mul_a = {r_v[0][31], r_v[0]}; mul_b = {1'b0, dt}; end
            ppu_pkg::ST_PY: begin mul_a = {r_v[1][31], r_v[1]}; mul_b = {1'b0, dt}; end
            ppu_pkg::ST_PZ: begin mul_a = {r_v[2][31], r_v[2]}; mul_b = {1'b0, dt}; end
            ppu_pkg::ST_VX: begin
                mul_a = {r_v[0][31], r_v[0]}; mul_b = {1'b0, i_cfg.decay_horizontal};
            end
            ppu_pkg::ST_VY: begin
                mul_a = {r_v[1][31], r_v[1]}; mul_b = {1'b0, i_cfg.decay_vertical};
            end
            ppu_pkg::ST_VZ: begin
                mul_a = {r_v[2][31], r_v[2]}; mul_b = {1'b0, i_cfg.decay_horizontal};
            end
            ppu_pkg::ST_G1: begin mul_a = {17'd0, i_cfg.growth_rate}; mul_b = {1'b0, dt}; end
            // size * grow, grow split in two 16-bit halves
            ppu_pkg::ST_G2: begin mul_a = {1'b0, r_sz}; mul_b = {1'b0, r_grow[15:0]}; end
            ppu_pkg::ST_G3: begin mul_a = {1'b0, r_sz}; mul_b = {1'b0, r_grow[31:16]}; end
            default: ;
        endcase
    end

    // position add with saturation; floor by arithmetic shift
    always_comb begin
        psum = 34'(r_p[0]) + 34'(r_prod[63:16]);
        case (r_state)
            ppu_pkg::ST_PY: psum = 34'(r_p[0]) + 34'(mul_p[49:16]);
            default: psum = 34'(r_p[0]) + 34'(mul_p[49:16]);
        endcase
        if (psum > 34'sd2147483647)       psat = 32'h7FFFFFFF;
        else if (psum < -34'sd2147483648) psat = 32'h80000000;
        else                              psat = psum[31:0];
    end

    logic [64:0] szsum;
    assign szsum = {33'd0, r_sz} + {1'b0, r_prod[63:28]}
                   + {29'd0, 36'(mul_p[47:0]) >> 12};

    logic [31:0] sz_next;
    assign sz_next = (szsum[64:32] != 33'd0) ? 32'hFFFFFFFF : szsum[31:0];

    assign in_ch.ready  = (r_state == ppu_pkg::ST_IDLE);
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ppu_pkg::ST_IDLE:
                if (in_ch.valid) begin
                    n_state = (in_ch.data.action == ppu_pkg::ACTION_SPAWN) ?
                              ppu_pkg::ST_SCAN : ppu_pkg::ST_TSCAN;
                end
            ppu_pkg::ST_SCAN:
                if (idx_end) n_state = ppu_pkg::ST_FULL;
                else if (r_life[idx_s] == 16'd0) n_state = ppu_pkg::ST_SPAWN;
            ppu_pkg::ST_SPAWN: n_state = ppu_pkg::ST_ALPHA;
            ppu_pkg::ST_FULL:
                if (!r_out_valid) n_state = ppu_pkg::ST_OUT;
            ppu_pkg::ST_TSCAN:
                if (idx_end) n_state = r_found ? ppu_pkg::ST_RD : ppu_pkg::ST_IDLE;
            ppu_pkg::ST_RD:
                if (idx_end) n_state = ppu_pkg::ST_IDLE;
                else if (r_life[idx_s] != 16'd0) n_state = ppu_pkg::ST_PX;
            ppu_pkg::ST_PX: n_state = ppu_pkg::ST_PY;
            ppu_pkg::ST_PY: n_state = ppu_pkg::ST_PZ;
            ppu_pkg::ST_PZ: n_state = ppu_pkg::ST_VX;
            ppu_pkg::ST_VX: n_state = ppu_pkg::ST_VY;
            ppu_pkg::ST_VY: n_state = ppu_pkg::ST_VZ;
            ppu_pkg::ST_VZ: n_state = ppu_pkg::ST_G1;
            ppu_pkg::ST_G1: n_state = ppu_pkg::ST_G2;
            ppu_pkg::ST_G2: n_state = ppu_pkg::ST_G3;
            ppu_pkg::ST_G3: n_state = ppu_pkg::ST_ALPHA;
            ppu_pkg::ST_ALPHA:
                if (r_div_skip || i_div_rsp.done) n_state = ppu_pkg::ST_EMIT;
            ppu_pkg::ST_EMIT:
                if (!r_out_valid) n_state = ppu_pkg::ST_OUT;
            ppu_pkg::ST_OUT:
                if (!r_out_valid || out_ch.ready) begin
                    n_state = (r_item.action == ppu_pkg::ACTION_TICK && !r_out.last) ?
                              ppu_pkg::ST_RD : ppu_pkg::ST_IDLE;
                end
            default: n_state = ppu_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ppu_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // divider request issued on entry to the alpha state
    logic div_start;
    assign div_start = (r_state == ppu_pkg::ST_SPAWN) || (r_state == ppu_pkg::ST_G3);
    always_comb begin
        o_div_req.start = div_start && (life_cur != 16'd0) && (i_cfg.life_max != 16'd0);
        o_div_req.num   = {life_cur, 8'd0} - {8'd0, life_cur};
        o_div_req.den   = i_cfg.life_max;
        if (r_state == ppu_pkg::ST_SPAWN) begin
            o_div_req.start = div_start && (i_cfg.life_max != 16'd0);
            o_div_req.num   = {i_cfg.life_max, 8'd0} - {8'd0, i_cfg.life_max};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < ppu_pkg::PARTICLES; i++) r_life[i] <= 16'd0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_out_valid <= 1'b0;
            case (r_state)
                ppu_pkg::ST_SPAWN: begin
                    r_life[r_slot] <= i_cfg.life_max;
                end
                ppu_pkg::ST_EMIT: begin
                    if (r_item.action == ppu_pkg::ACTION_TICK && !r_out_valid) begin
                        r_life[r_slot] <= (life_cur > dt) ? life_cur - dt : 16'd0;
                    end
                end
                ppu_pkg::ST_OUT: begin
                    if (!r_out_valid || out_ch.ready) r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ppu_pkg::ST_IDLE: begin
                r_item  <= in_ch.data;
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            ppu_pkg::ST_SCAN: begin
                r_slot <= idx_s;
                if (!idx_end) r_idx <= r_idx + CW'(1);
            end
            ppu_pkg::ST_SPAWN: begin
                pos_mem[r_slot][0] <= r_item.spawn_x;
                pos_mem[r_slot][1] <= r_item.spawn_y;
                pos_mem[r_slot][2] <= r_item.spawn_z;
                vel_mem[r_slot][0] <= r_item.start_vx;
                vel_mem[r_slot][1] <= r_item.start_vy;
                vel_mem[r_slot][2] <= r_item.start_vz;
                size_mem[r_slot]   <= i_cfg.start_size;
                r_p[0] <= r_item.spawn_x;
                r_p[1] <= r_item.spawn_y;
                r_p[2] <= r_item.spawn_z;
                r_sz   <= i_cfg.start_size;
                r_div_skip <= (i_cfg.life_max == 16'd0);
                r_alpha    <= 8'd0;
            end
            ppu_pkg::ST_TSCAN: begin
                if (idx_end) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + CW'(1);
                    if (r_life[idx_s] != 16'd0) begin
                        r_found   <= 1'b1;
                        r_lastidx <= idx_s;
                    end
                end
            end
            ppu_pkg::ST_RD: begin
                r_slot <= idx_s;
                if (!idx_end) r_idx <= r_idx + CW'(1);
                r_p[0] <= pos_mem[idx_s][0];
                r_p[1] <= pos_mem[idx_s][1];
                r_p[2] <= pos_mem[idx_s][2];
                r_v[0] <= vel_mem[idx_s][0];
                r_v[1] <= vel_mem[idx_s][1];
                r_v[2] <= vel_mem[idx_s][2];
                r_sz   <= size_mem[idx_s];
            end
            // positions rotate through r_p[0] so one adder serves all axes
            ppu_pkg::ST_PX, ppu_pkg::ST_PY, ppu_pkg::ST_PZ: begin
                r_p[0] <= r_p[1];
                r_p[1] <= r_p[2];
                r_p[2] <= psat;
            end
            ppu_pkg::ST_VX: r_v[0] <= mul_p[47:16];
            ppu_pkg::ST_VY: r_v[1] <= mul_p[47:16];
            ppu_pkg::ST_VZ: r_v[2] <= mul_p[47:16];
            ppu_pkg::ST_G1: r_grow <= mul_p[31:0];
            ppu_pkg::ST_G2: r_prod <= {16'd0, mul_p[47:0]};
            ppu_pkg::ST_G3: begin
                // prod = lo + hi<<16; size += prod>>28
                r_prod <= 64'({r_prod[63:0]} + {mul_p[47:0], 16'd0});
                r_div_skip <= (life_cur == 16'd0) || (i_cfg.life_max == 16'd0);
                r_alpha    <= (life_cur == 16'd0) ? 8'd0 : 8'hFF;
            end
            ppu_pkg::ST_ALPHA: begin
                if (i_div_rsp.done) r_alpha <= i_div_rsp.quo;
            end
            ppu_pkg::ST_EMIT: begin
                if (r_item.action == ppu_pkg::ACTION_TICK && !r_out_valid) begin
                    pos_mem[r_slot][0] <= r_p[0];
                    pos_mem[r_slot][1] <= r_p[1];
                    pos_mem[r_slot][2] <= r_p[2];
                    vel_mem[r_slot][0] <= r_v[0];
                    vel_mem[r_slot][1] <= r_v[1];
                    vel_mem[r_slot][2] <= r_v[2];
                    size_mem[r_slot]   <= sz_next;
                end
            end
            default: ;
        endcase
        if (r_state == ppu_pkg::ST_EMIT && !r_out_valid &&
            r_item.action == ppu_pkg::ACTION_TICK) begin
            r_sz <= sz_next;
        end
        // hold off while the previous report still waits for its transfer
        if (r_state == ppu_pkg::ST_EMIT && !r_out_valid) begin
            r_out.accepted <= 1'b1;
            r_out.slot     <= 6'(r_slot);
            r_out.cur_x    <= r_p[0];
            r_out.cur_y    <= r_p[1];
            r_out.cur_z    <= r_p[2];
            r_out.alpha    <= r_alpha;
            r_out.last     <= (r_item.action == ppu_pkg::ACTION_SPAWN) ||
                              (r_slot == r_lastidx);
        end
        if (r_state == ppu_pkg::ST_OUT && (!r_out_valid || out_ch.ready)) begin
            r_out.cur_size <= r_sz;
        end
        if (r_state == ppu_pkg::ST_FULL && !r_out_valid) begin
            r_out <= ppu_pkg::t_out_item'{last: 1'b1, default: '0};
            r_sz  <= 32'd0;
        end
    end
endmodule

/* sv/particle_pool_update_unit.sv */
// ----------------------------------------------------------------------------
// particle_pool_update_unit
// Fixed pool of particles updated by spawn and tick items.
// ----------------------------------------------------------------------------
// Spawn: a scan for a free slot, then the alpha divide when one is found.
// Tick: a scan for live slots, then for each live slot the shared
// multiplier sequence and the bit-serial alpha divider; a report
// still waiting for its transfer holds the next one back.
// One item at a time; in_ch.ready only while idle.
// Synchronous active-low reset clears all lives (every slot free) and
// restores the register defaults.
module particle_pool_update_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ppu_in_if.sink                      in_ch,
    ppu_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ppu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    ppu_pkg::t_cfg     cfg;
    ppu_pkg::t_div_req div_req;
    ppu_pkg::t_div_rsp div_rsp;

    ppu_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    ppu_div u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));

    ppu_core u_core (
        .i_clk, .i_rst_n, .i_cfg(cfg), .in_ch, .out_ch,
        .o_div_req(div_req), .i_div_rsp(div_rsp)
    );
endmodule

/* tb/sv/particle_pool_update_unit_tb.sv */
// ----------------------------------------------------------------------------
// particle_pool_update_unit_tb
// Drives spawn and tick items with random idling on both channels, writes the
// registers between phases, and checks every report against a predicted pool.
// ----------------------------------------------------------------------------
class pool_scoreboard;
    logic [15:0] life_max, decay_h, decay_v, growth;
    logic [31:0] start_size;
    logic [15:0] life_q[32];
    longint      pos_q[32][3];
    longint      vel_q[32][3];
    longint unsigned size_q[32];
    ppu_pkg::t_out_item reports_due[$];
    int          errors;

    function new();
        life_max = 16'd13107;
        decay_h = 16'd3277;
        decay_v = 16'd32768;
        growth = 16'd8192;
        start_size = 32'd16384;
        errors = 0;
        foreach (life_q[i]) life_q[i] = '0;
    endfunction

    function longint fl16(longint p);
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function logic [7:0] alpha_for(logic [15:0] life);
        longint a;
        if (life == 0) return 8'd0;
        if (life_max == 0) return 8'd255;
        a = (longint'(life) * 255) / longint'(life_max);
        return (a > 255) ? 8'd255 : a[7:0];
    endfunction

    function ppu_pkg::t_out_item report_of(int s, logic [7:0] a, logic lst);
        ppu_pkg::t_out_item r;
        r.accepted = 1'b1;
        r.slot = s[5:0];
        r.cur_x = pos_q[s][0][31:0];
        r.cur_y = pos_q[s][1][31:0];
        r.cur_z = pos_q[s][2][31:0];
        r.cur_size = size_q[s][31:0];
        r.alpha = a;
        r.last = lst;
        return r;
    endfunction

    function void note_item(ppu_pkg::t_in_item it);
        int lastidx;
        longint p;
        longint unsigned sz, grow;
        logic [7:0] a;
        logic signed [31:0] sp[3];
        logic signed [31:0] sv[3];
        lastidx = -1;
        sp = '{it.spawn_x, it.spawn_y, it.spawn_z};
        sv = '{it.start_vx, it.start_vy, it.start_vz};
        if (it.action == ppu_pkg::ACTION_SPAWN) begin
            for (int i = 0; i < 32; i++) begin
                if (life_q[i] == 0) begin
                    for (int k = 0; k < 3; k++) begin
                        pos_q[i][k] = longint'(sp[k]);
                        vel_q[i][k] = longint'(sv[k]);
                    end
                    size_q[i] = start_size;
                    life_q[i] = life_max;
                    reports_due.push_back(report_of(i, alpha_for(life_max), 1'b1));
                    return;
                end
            end
            reports_due.push_back('{accepted: 1'b0, slot: '0, cur_x: '0, cur_y: '0,
                cur_z: '0, cur_size: '0, alpha: '0, last: 1'b1});
            return;
        end
        for (int i = 0; i < 32; i++) if (life_q[i] != 0) lastidx = i;
        for (int i = 0; i < 32; i++) begin
            if (life_q[i] == 0) continue;
            for (int k = 0; k < 3; k++) begin
                p = pos_q[i][k] + fl16(vel_q[i][k] * longint'(it.time_step));
                if (p > 64'sd2147483647) p = 64'sd2147483647;
                if (p < -64'sd2147483648) p = -64'sd2147483648;
                pos_q[i][k] = p;
                vel_q[i][k] = fl16(vel_q[i][k] * longint'((k == 1) ? decay_v : decay_h));
            end
            grow = 64'(growth) * 64'(it.time_step);
            sz = size_q[i] + ((size_q[i] * grow) >> 28);
            size_q[i] = (sz > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sz;
            a = alpha_for(life_q[i]);
            life_q[i] = (life_q[i] > it.time_step) ? life_q[i] - it.time_step : 16'd0;
            reports_due.push_back(report_of(i, a, i == lastidx));
        end
    endfunction

    function void check_report(ppu_pkg::t_out_item got);
        ppu_pkg::t_out_item want;
        if (reports_due.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual %h", $realtime, got);
            errors++;
            return;
        end
        want = reports_due.pop_front();
        if (got !== want) begin
            $display("%0t: report mismatch, expected %h, actual %h", $realtime, want, got);
            errors++;
        end
    endfunction
endclass

module particle_pool_update_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ppu_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          send_idle_pct = 0, recv_stall_pct = 0;
    int          rand_mode = 0;
    pool_scoreboard pool = new();

    ppu_in_if  in_ch();
    ppu_out_if out_ch();

    particle_pool_update_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stall, checks on the rising edge
    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) pool.check_report(out_ch.data);
        if (i_rst_n && in_ch.valid && in_ch.ready) pool.note_item(in_ch.data);
    end

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            ADDR_LIFE_MAX:    pool.life_max = val[15:0];
            ADDR_DECAY_HORIZ: pool.decay_h = val[15:0];
            ADDR_DECAY_VERT:  pool.decay_v = val[15:0];
            ADDR_GROWTH_RATE: pool.growth = val[15:0];
            default:          pool.start_size = val;
        endcase
    endtask

    task automatic drain();
        while (pool.reports_due.size() != 0) @(posedge i_clk);
        // a tick with no live slot may still be scanning
        repeat (100) @(posedge i_clk);
    endtask

    task automatic send_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return $urandom & 32'h0003_FFFF;
            2: return -($urandom & 32'h0003_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item rand_item(int tick_pct);
        t_in_item it;
        it.action = ($urandom_range(99) < tick_pct) ? ACTION_TICK : ACTION_SPAWN;
        it.spawn_x = rand_word(); it.spawn_y = rand_word(); it.spawn_z = rand_word();
        it.start_vx = rand_word(); it.start_vy = rand_word(); it.start_vz = rand_word();
        case ($urandom_range(3))
            0: it.time_step = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: it.time_step = 16'($urandom_range(2000));
            default: it.time_step = 16'($urandom);
        endcase
        return it;
    endfunction

    task automatic set_all(logic [15:0] lm, logic [15:0] dh, logic [15:0] dv,
                           logic [15:0] gr, logic [31:0] ss);
        reg_write(ADDR_LIFE_MAX, {16'h0, lm});
        reg_write(ADDR_DECAY_HORIZ, {16'h0, dh});
        reg_write(ADDR_DECAY_VERT, {16'h0, dv});
        reg_write(ADDR_GROWTH_RATE, {16'h0, gr});
        reg_write(ADDR_START_SIZE, ss);
    endtask

    initial begin
        t_in_item it;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, full pool, empty tick, zero and lowered life_max
        it = '0;
        it.action = ACTION_TICK; it.time_step = 16'd100;
        send_item(it);
        it = '0;
        it.action = ACTION_SPAWN;
        it.spawn_x = 32'h7FFF_FFFF; it.spawn_y = 32'h8000_0000; it.spawn_z = 32'hFFFF_FFFF;
        it.start_vx = 32'h7FFF_FFFF; it.start_vy = 32'h8000_0000; it.start_vz = 32'h0001_0000;
        send_item(it);
        it.action = ACTION_TICK; it.time_step = 16'hFFFF;
        send_item(it);
        drain();
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        for (int n = 0; n < 34; n++) begin
            it = rand_item(0);
            send_item(it);
            if (n == 4) begin
                it.action = ACTION_TICK; it.time_step = 16'd1;
                send_item(it);
            end
        end
        drain();
        reg_write(ADDR_LIFE_MAX, 32'd0);
        it.action = ACTION_TICK; it.time_step = 16'd3;
        send_item(it);
        drain();
        reg_write(ADDR_LIFE_MAX, 32'd100);
        send_item(it);
        it.time_step = 16'hFFFF;
        send_item(it);
        it.action = ACTION_SPAWN;
        send_item(it);
        drain();
        reg_write(ADDR_LIFE_MAX, 32'd0);
        send_item(it);
        drain();

        // random phases with different idling and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            if (ph == 7)
                set_all(16'd1, 16'd0, 16'd0, 16'd0, 32'd0);
            else
                set_all(16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom),
                        16'($urandom), $urandom);
            for (int n = 0; n < 60; n++) send_item(rand_item(40));
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (pool.errors == 0 && pool.reports_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* particle_pool_update_unit.f */
sv/ppu_pkg.sv
sv/ppu_if.sv
sv/ppu_cfg.sv
sv/ppu_div.sv
sv/ppu_core.sv
sv/particle_pool_update_unit.sv
tb/sv/particle_pool_update_unit_tb.sv
